@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/mbrtu_pkg.sv @@
// Types, constants and CRC helpers of the Modbus RTU master.
`timescale 1ns / 1ps
package mbrtu_pkg;
	localparam int BUFFER_BYTES = 64;
	localparam int BUF_AW = $clog2(BUFFER_BYTES);
	localparam int CNT_W = BUF_AW + 1;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TX_DONE = 2'd1,
		OP_RX_BYTE = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_WORD = 2'd1,
		KIND_STATUS = 2'd2,
		KIND_DIR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SEND = 3'd1,
		PH_RECV = 3'd2,
		PH_DONE = 3'd3,
		PH_FAIL = 3'd4
	} phase_t;

	localparam logic [1:0] CFG_BYTE_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_RESP_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_EXC_FUNCTION = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [10:0] SILENCE_MAX = 11'd2047;

	// One bit step of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc_bit(input logic [15:0] crc);
		crc_bit = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
	endfunction
endpackage

@@ rtl/mbrtu_in_if.sv @@
// Input item channel of the Modbus RTU master.
`timescale 1ns / 1ps
interface mbrtu_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [7:0] slave_addr;
	logic [7:0] function_code;
	logic [15:0] start_register;
	logic [4:0] register_count;
	logic [7:0] rx_byte;
	modport source (output valid, op, slave_addr, function_code, start_register,
		register_count, rx_byte, input ready);
	modport sink (input valid, op, slave_addr, function_code, start_register,
		register_count, rx_byte, output ready);
endinterface

@@ rtl/mbrtu_out_if.sv @@
// Result item channel of the Modbus RTU master.
`timescale 1ns / 1ps
interface mbrtu_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [15:0] value;
	logic last;
	modport source (output valid, kind, value, last, input ready);
	modport sink (input valid, kind, value, last, output ready);
endinterface

@@ rtl/mbrtu_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/modbus_rtu_master_transaction.sv @@
// Top level of the Modbus RTU master for one read-registers transaction.
`timescale 1ns / 1ps
// Items enter on in_ch (valid/ready); results leave on out_ch with last set on
// the final result of each item. cfg_we/cfg_index/cfg_data write the byte
// timeout, response timeout and exception function code.
// in_ch.ready is high only while the sequencer is idle. A received byte and a
// tick that ends nothing are handled in the idle state. A start item runs the
// request bytes through a bit-serial CRC and then emits 9 results, one per
// cycle while the receiver takes them. A transmit done emits one result. A
// tick that ends a frame of the expected length walks the receive buffer
// through the same bit-serial CRC, byte by byte, then reads each register word.
// Both walks use the shared CRC bit step.
// Reset clears the sequencer, counters and phase and restores the register
// defaults; the buffer needs no clearing. Results sit in one output register;
// while the receiver stalls the sequencer waits in an emit state, but idle it accepts items.
module modbus_rtu_master_transaction (
	input logic clk,
	input logic arst_n,
	mbrtu_in_if.sink in_ch,
	mbrtu_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [9:0] cfg_data
);
	import mbrtu_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_REQ_BYTE = 11'b00000000010,
		S_REQ_BIT = 11'b00000000100,
		S_REQ_EMIT = 11'b00000001000,
		S_CHK_RD = 11'b00000010000,
		S_CHK_BYTE = 11'b00000100000,
		S_CHK_BIT = 11'b00001000000,
		S_W_RDH = 11'b00010000000,
		S_W_RDL = 11'b00100000000,
		S_W_EMIT = 11'b01000000000,
		S_ONE = 11'b10000000000
	} state_t;

	state_t state_q;
	phase_t phase_q;
	logic [7:0] byte_to_q, exc_fn_q;
	logic [9:0] resp_to_q;
	logic [CNT_W-1:0] rx_count_q;
	logic ovf_q;
	logic [10:0] silence_q;
	logic [7:0] addr_q, fc_q, hi_q, crc_lo_q;
	logic [15:0] reg_q, crc_q;
	logic [4:0] regs_q;
	logic [6:0] idx_q;
	logic [2:0] bit_q;
	logic bad_q;
	logic [1:0] one_kind_q;
	logic [15:0] one_val_q;
	logic out_valid_q, out_last_q;
	logic [1:0] out_kind_q;
	logic [15:0] out_value_q;

	logic accept, slot_free, ram_we, out_load;
	logic [BUF_AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic [6:0] dlen, frame_len, crc_end;
	logic [10:0] silence_nxt, limit;
	logic [7:0] req_byte;
	logic [1:0] emit_kind;
	logic [15:0] emit_val;
	logic [6:0] idx_p1;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ch.ready;
	// The output register takes a new result in this cycle.
	assign out_load = slot_free
		&& (state_q == S_REQ_EMIT || state_q == S_W_EMIT || state_q == S_ONE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = out_kind_q;
	assign out_ch.value = out_value_q;
	assign out_ch.last = out_last_q;

	assign dlen = {1'b0, regs_q, 1'b0};
	assign frame_len = dlen + 7'd5;
	assign crc_end = dlen + 7'd3;
	assign idx_p1 = idx_q + 7'd1;
	assign silence_nxt = (silence_q == SILENCE_MAX) ? silence_q : silence_q + 11'd1;
	assign limit = (rx_count_q != '0) ? {3'b000, byte_to_q} : {1'b0, resp_to_q};

	assign ram_we = accept && (op_t'(in_ch.op) == OP_RX_BYTE) && (phase_q == PH_RECV)
		&& (rx_count_q < CNT_W'(BUFFER_BYTES));
	assign ram_raddr = (state_q == S_W_RDL || state_q == S_W_EMIT) ?
		idx_p1[BUF_AW-1:0] : idx_q[BUF_AW-1:0];

	mbrtu_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_rx_buf (
		.clk(clk),
		.we(ram_we),
		.waddr(rx_count_q[BUF_AW-1:0]),
		.wdata(in_ch.rx_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request byte by position; the count high byte is always zero.
	always_comb begin
		unique case (idx_q[2:0])
			3'd0: req_byte = addr_q;
			3'd1: req_byte = fc_q;
			3'd2: req_byte = reg_q[15:8];
			3'd3: req_byte = reg_q[7:0];
			3'd5: req_byte = {3'b000, regs_q};
			default: req_byte = 8'd0;
		endcase
	end

	// Request emission order: direction, six request bytes, CRC low, CRC high.
	always_comb begin
		priority if (idx_q == 7'd0) begin
			emit_kind = KIND_DIR;
			emit_val = 16'd1;
		end else if (idx_q == 7'd7) begin
			emit_kind = KIND_BYTE;
			emit_val = {8'd0, crc_q[7:0]};
		end else if (idx_q == 7'd8) begin
			emit_kind = KIND_BYTE;
			emit_val = {8'd0, crc_q[15:8]};
		end else begin
			emit_kind = KIND_BYTE;
			unique case (idx_q[2:0])
				3'd1: emit_val = {8'd0, addr_q};
				3'd2: emit_val = {8'd0, fc_q};
				3'd3: emit_val = {8'd0, reg_q[15:8]};
				3'd4: emit_val = {8'd0, reg_q[7:0]};
				3'd6: emit_val = {11'd0, regs_q};
				default: emit_val = 16'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_to_q <= 8'd5;
			resp_to_q <= 10'd30;
			exc_fn_q <= 8'd131;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BYTE_TIMEOUT: byte_to_q <= cfg_data[7:0];
				CFG_RESP_TIMEOUT: resp_to_q <= cfg_data;
				CFG_EXC_FUNCTION: exc_fn_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			rx_count_q <= '0;
			ovf_q <= 1'b0;
			silence_q <= '0;
			addr_q <= '0;
			regs_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op_t'(in_ch.op))
							OP_START: begin
								addr_q <= in_ch.slave_addr;
								fc_q <= in_ch.function_code;
								reg_q <= in_ch.start_register;
								regs_q <= in_ch.register_count;
								rx_count_q <= '0;
								ovf_q <= 1'b0;
								silence_q <= '0;
								phase_q <= PH_SEND;
								crc_q <= CRC_INIT;
								idx_q <= '0;
								state_q <= S_REQ_BYTE;
							end
							OP_TX_DONE: begin
								if (phase_q == PH_SEND) begin
									phase_q <= PH_RECV;
									silence_q <= '0;
									one_kind_q <= KIND_DIR;
									one_val_q <= 16'd0;
									state_q <= S_ONE;
								end
							end
							OP_RX_BYTE: begin
								if (phase_q == PH_RECV) begin
									if (rx_count_q < CNT_W'(BUFFER_BYTES)) begin
										rx_count_q <= rx_count_q + CNT_W'(1);
									end else begin
										ovf_q <= 1'b1;
									end
									silence_q <= '0;
								end
							end
							OP_TICK: begin
								if (phase_q == PH_RECV) begin
									silence_q <= silence_nxt;
									if (silence_nxt > limit) begin
										if (ovf_q || (rx_count_q != CNT_W'(frame_len))) begin
											phase_q <= PH_FAIL;
											one_kind_q <= KIND_STATUS;
											one_val_q <= 16'd1;
											state_q <= S_ONE;
										end else begin
											idx_q <= '0;
											bad_q <= 1'b0;
											crc_q <= CRC_INIT;
											state_q <= S_CHK_RD;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_REQ_BYTE: begin
					crc_q <= crc_q ^ {8'd0, req_byte};
					bit_q <= '0;
					state_q <= S_REQ_BIT;
				end
				S_REQ_BIT: begin
					crc_q <= crc_bit(crc_q);
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (idx_q == 7'd5) begin
							idx_q <= '0;
							state_q <= S_REQ_EMIT;
						end else begin
							idx_q <= idx_p1;
							state_q <= S_REQ_BYTE;
						end
					end
				end
				S_REQ_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= emit_kind;
						out_value_q <= emit_val;
						out_last_q <= (idx_q == 7'd8);
						idx_q <= idx_p1;
						if (idx_q == 7'd8) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CHK_RD: begin
					state_q <= S_CHK_BYTE;
				end
				S_CHK_BYTE: begin
					if ((idx_q == 7'd0 && ram_rdata != addr_q)
						|| (idx_q == 7'd1 && ram_rdata == exc_fn_q)
						|| (idx_q == 7'd2 && ram_rdata != {1'b0, dlen})) begin
						bad_q <= 1'b1;
					end
					priority if (idx_q < crc_end) begin
						crc_q <= crc_q ^ {8'd0, ram_rdata};
						bit_q <= '0;
						state_q <= S_CHK_BIT;
					end else if (idx_q == crc_end) begin
						crc_lo_q <= ram_rdata;
						idx_q <= idx_p1;
						state_q <= S_CHK_RD;
					end else begin
						if (!bad_q && {ram_rdata, crc_lo_q} == crc_q) begin
							if (regs_q != '0) begin
								idx_q <= 7'd3;
								state_q <= S_W_RDH;
							end else begin
								phase_q <= PH_DONE;
								one_kind_q <= KIND_STATUS;
								one_val_q <= 16'd0;
								state_q <= S_ONE;
							end
						end else begin
							phase_q <= PH_FAIL;
							one_kind_q <= KIND_STATUS;
							one_val_q <= 16'd1;
							state_q <= S_ONE;
						end
					end
				end
				S_CHK_BIT: begin
					crc_q <= crc_bit(crc_q);
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						idx_q <= idx_p1;
						state_q <= S_CHK_RD;
					end
				end
				S_W_RDH: begin
					state_q <= S_W_RDL;
				end
				S_W_RDL: begin
					hi_q <= ram_rdata;
					state_q <= S_W_EMIT;
				end
				S_W_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= KIND_WORD;
						out_value_q <= {hi_q, ram_rdata};
						out_last_q <= 1'b0;
						idx_q <= idx_q + 7'd2;
						if (idx_q + 7'd2 == crc_end) begin
							phase_q <= PH_DONE;
							one_kind_q <= KIND_STATUS;
							one_val_q <= 16'd0;
							state_q <= S_ONE;
						end else begin
							state_q <= S_W_RDH;
						end
					end
				end
				S_ONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= one_kind_q;
						out_value_q <= one_val_q;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, rx_count_q <= CNT_W'(BUFFER_BYTES))
	`ASSERT_NEXT(a_start_crc, clk, arst_n, accept && op_t'(in_ch.op) == OP_START, state_q == S_REQ_BYTE)
	`ASSERT_SAME(a_words_need_regs, clk, arst_n, state_q == S_W_EMIT, regs_q != 5'd0)
endmodule

@@ verif/tb_modbus_rtu_master_transaction.sv @@
// Self-checking testbench of the Modbus RTU master read transaction.
`timescale 1ns / 1ps
module tb_modbus_rtu_master_transaction;
	import mbrtu_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] slave_addr;
		logic [7:0] function_code;
		logic [15:0] start_register;
		logic [4:0] register_count;
		logic [7:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] value;
		logic last;
	} reply_t;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	mbrtu_in_if in_ch();
	mbrtu_out_if out_ch();

	modbus_rtu_master_transaction dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state.
	logic [7:0] m_byte_to, m_exc_fn;
	logic [9:0] m_resp_to;
	phase_t m_phase;
	logic [7:0] m_buf [BUFFER_BYTES];
	int m_count;
	bit m_ovf;
	int m_silence;
	logic [7:0] m_addr;
	logic [4:0] m_regs;

	req_item_t pending[$];
	reply_t expected_replies[$];
	int errors = 0;
	int n_items = 0, n_replies = 0, n_words = 0, n_good = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	function automatic logic [15:0] crc_of(input logic [7:0] d [], input int len);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < len; i++) begin
			c ^= {8'h00, d[i]};
			for (int b = 0; b < 8; b++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic bit frame_ok();
		logic [7:0] d [];
		int data;
		logic [15:0] got;
		data = 2 * m_regs;
		if (m_ovf || m_count != 5 + data) return 0;
		if (m_buf[0] != m_addr || m_buf[1] == m_exc_fn || m_buf[2] != data) return 0;
		d = new[data + 3];
		for (int i = 0; i < data + 3; i++) d[i] = m_buf[i];
		got = {m_buf[data + 4], m_buf[data + 3]};
		return got == crc_of(d, data + 3);
	endfunction

	task automatic push_reply(input kind_t k, input logic [15:0] v, inout int n);
		expected_replies.push_back('{kind: k, value: v, last: 1'b0});
		n++;
	endtask

	task automatic predict(input req_item_t it);
		int n, limit;
		logic [7:0] rq [];
		logic [15:0] c;
		n = 0;
		case (it.op)
			OP_START: begin
				m_addr = it.slave_addr;
				m_regs = it.register_count;
				rq = new[6];
				rq[0] = it.slave_addr; rq[1] = it.function_code;
				rq[2] = it.start_register[15:8]; rq[3] = it.start_register[7:0];
				rq[4] = 8'h00; rq[5] = {3'b000, it.register_count};
				c = crc_of(rq, 6);
				m_count = 0; m_ovf = 0; m_silence = 0; m_phase = PH_SEND;
				push_reply(KIND_DIR, 16'd1, n);
				for (int i = 0; i < 6; i++) push_reply(KIND_BYTE, {8'h00, rq[i]}, n);
				push_reply(KIND_BYTE, {8'h00, c[7:0]}, n);
				push_reply(KIND_BYTE, {8'h00, c[15:8]}, n);
			end
			OP_TX_DONE: if (m_phase == PH_SEND) begin
				m_phase = PH_RECV; m_silence = 0;
				push_reply(KIND_DIR, 16'd0, n);
			end
			OP_RX_BYTE: if (m_phase == PH_RECV) begin
				if (m_count < BUFFER_BYTES) begin
					m_buf[m_count] = it.rx_byte; m_count++;
				end else m_ovf = 1;
				m_silence = 0;
			end
			default: if (m_phase == PH_RECV) begin
				limit = m_count != 0 ? m_byte_to : m_resp_to;
				if (m_silence < 2047) m_silence++;
				if (m_silence > limit) begin
					if (frame_ok()) begin
						for (int i = 0; i < m_regs; i++) begin
							push_reply(KIND_WORD, {m_buf[3 + 2 * i], m_buf[4 + 2 * i]}, n);
							n_words++;
						end
						m_phase = PH_DONE; n_good++;
						push_reply(KIND_STATUS, 16'd0, n);
					end else begin
						m_phase = PH_FAIL;
						push_reply(KIND_STATUS, 16'd1, n);
					end
				end
			end
		endcase
		if (n > 0) expected_replies[$].last = 1'b1;
	endtask

	task automatic report(input string what, input reply_t got, input reply_t want);
		errors++;
		$display("mismatch %s: got kind %0d value %h last %0d, want kind %0d value %h last %0d",
			what, got.kind, got.value, got.last, want.kind, want.value, want.last);
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// Driver.
	int in_gap = 0;
	bit burst = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.op <= '0;
			in_ch.slave_addr <= '0;
			in_ch.function_code <= '0;
			in_ch.start_register <= '0;
			in_ch.register_count <= '0;
			in_ch.rx_byte <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict(pending.pop_front());
				n_items++;
				in_gap = burst ? 0 : gap_len();
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_gap > 0) in_gap--;
				if (in_gap == 0 && pending.size() > 0
					&& !(hold_off && expected_replies.size() > 0)) begin
					in_ch.valid <= 1'b1;
					in_ch.op <= pending[0].op;
					in_ch.slave_addr <= pending[0].slave_addr;
					in_ch.function_code <= pending[0].function_code;
					in_ch.start_register <= pending[0].start_register;
					in_ch.register_count <= pending[0].register_count;
					in_ch.rx_byte <= pending[0].rx_byte;
				end else in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor.
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		reply_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{kind: out_ch.kind, value: out_ch.value, last: out_ch.last};
				n_replies++;
				if (expected_replies.size() == 0) begin
					report("unexpected", got, '0);
				end else begin
					want = expected_replies.pop_front();
					if (got.kind != want.kind) report("kind", got, want);
					else if (got.value != want.value) report("value", got, want);
					else if (got.last != want.last) report("last", got, want);
				end
				out_gap = burst ? 0 : gap_len();
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else out_ch.ready <= 1'b1;
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("** modbus_rtu_master_transaction: FAILED **");
				$finish;
			end
		end
	end

	function automatic req_item_t mk(input op_t op, input logic [7:0] b);
		req_item_t it;
		it = '{op: op, slave_addr: 8'($urandom), function_code: 8'($urandom),
			start_register: 16'($urandom), register_count: 5'($urandom), rx_byte: b};
		return it;
	endfunction

	task automatic add_start(input logic [7:0] a, input logic [7:0] f,
			input logic [15:0] r, input logic [4:0] c);
		req_item_t it;
		it = mk(OP_START, 8'($urandom));
		it.slave_addr = a; it.function_code = f; it.start_register = r;
		it.register_count = c;
		pending.push_back(it);
	endtask

	// Queues a reply frame; flaw 0 well formed, 1 to 3 corrupt address, count or CRC, 4 cuts, 5 adds a byte.
	task automatic add_reply(input logic [7:0] a, input logic [4:0] c, input int flaw,
			input logic [7:0] fn);
		logic [7:0] d [];
		logic [15:0] cc;
		int len;
		len = 5 + 2 * c;
		d = new[len];
		d[0] = (flaw == 1) ? a ^ 8'h01 : a;
		d[1] = fn;
		d[2] = (flaw == 2) ? 8'(2 * c + 2) : 8'(2 * c);
		for (int i = 3; i < len - 2; i++) d[i] = 8'($urandom);
		cc = crc_of(d, len - 2);
		if (flaw == 3) cc ^= 16'h0100;
		d[len - 2] = cc[7:0]; d[len - 1] = cc[15:8];
		if (flaw == 4) len--;
		for (int i = 0; i < len; i++) pending.push_back(mk(OP_RX_BYTE, d[i]));
		if (flaw == 5) pending.push_back(mk(OP_RX_BYTE, 8'($urandom)));
	endtask

	task automatic add_ticks(input int n);
		for (int i = 0; i < n; i++) pending.push_back(mk(OP_TICK, 8'h00));
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_replies.size() > 0) @(posedge clk);
		// A closing tick can leave the block busy with no result pending.
		repeat (700) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [9:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BYTE_TIMEOUT: m_byte_to = v[7:0];
			CFG_RESP_TIMEOUT: m_resp_to = v;
			default: m_exc_fn = v[7:0];
		endcase
	endtask

	initial begin
		int sel, c, fl, btmax;
		logic [7:0] a;
		m_byte_to = 8'd5; m_resp_to = 10'd30; m_exc_fn = 8'd131;
		m_phase = PH_IDLE; m_count = 0; m_ovf = 0; m_silence = 0;
		m_addr = '0; m_regs = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ignored items while idle, extremes, exception, overflow.
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		pending.push_back(mk(OP_RX_BYTE, 8'hFF));
		pending.push_back(mk(OP_TICK, 8'h00));
		add_start(8'hFF, 8'hFF, 16'hFFFF, 5'd29);
		pending.push_back(mk(OP_RX_BYTE, 8'h55));
		pending.push_back(mk(OP_TICK, 8'h00));
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		add_reply(8'hFF, 5'd1, 0, 8'h03);
		add_ticks(7);
		pending.push_back(mk(OP_TICK, 8'h00));
		drain();
		write_cfg(CFG_BYTE_TIMEOUT, 10'd0);
		write_cfg(CFG_RESP_TIMEOUT, 10'd0);
		write_cfg(CFG_EXC_FUNCTION, 10'd255);
		add_start(8'h00, 8'h00, 16'h0000, 5'd0);
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		add_ticks(1);
		add_start(8'h11, 8'hFF, 16'h0000, 5'd0);
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		add_reply(8'h11, 5'd0, 0, 8'hFF);
		add_ticks(1);
		add_start(8'h22, 8'h03, 16'h1234, 5'd29);
		pending.push_back(mk(OP_TX_DONE, 8'h00));
		for (int i = 0; i < 66; i++) pending.push_back(mk(OP_RX_BYTE, 8'($urandom)));
		add_ticks(2);
		hold_off = 1'b1;
		drain();
		hold_off = 1'b0;

		// Random phases under several settings.
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(CFG_BYTE_TIMEOUT, 10'($urandom_range(0, 4)));
			write_cfg(CFG_RESP_TIMEOUT, ph == 2 ? 10'd1023 : 10'($urandom_range(0, 12)));
			write_cfg(CFG_EXC_FUNCTION, ph == 0 ? 10'd0 : 10'($urandom_range(0, 255)));
			btmax = m_byte_to;
			burst = (ph == 1);
			for (int t = 0; t < 1; t++) begin
				a = 8'($urandom);
				c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 29) : $urandom_range(0, 4);
				add_start(a, 8'($urandom), 16'($urandom), 5'(c));
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					pending.push_back(mk(OP_RX_BYTE, 8'($urandom)));
					pending.push_back(mk(OP_TX_DONE, 8'h00));
				end else begin
					pending.push_back(mk(OP_TX_DONE, 8'h00));
					fl = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
					if (fl == 6) add_reply(a, 5'(c), 0, m_exc_fn);
					else add_reply(a, 5'(c), fl, 8'($urandom_range(1, 4)) ^ m_exc_fn);
					if (ph != 2 && $urandom_range(0, 5) == 0) add_ticks(1);
					if (ph != 2 && $urandom_range(0, 5) == 0)
						pending.push_back(mk(OP_RX_BYTE, 8'($urandom)));
					add_ticks(btmax + 1);
				end
			end
			drain();
		end
		burst = 1'b0;
		$display("covered %0d items, %0d results, %0d good frames, %0d register words",
			n_items, n_replies, n_good, n_words);
		if (errors == 0) begin
			$display("** modbus_rtu_master_transaction: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** modbus_rtu_master_transaction: FAILED **");
		end
		$finish;
	end
endmodule
